@@ design/calendar_date_stepper_core_macros.svh @@
// Assertion macros for the calendar date stepper checker.
`ifndef CALENDAR_DATE_STEPPER_CORE_MACROS_SVH
`define CALENDAR_DATE_STEPPER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cds_pkg.sv @@
// Shared types, constants and functions of the calendar date stepper.
package cds_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int YEAR_W          = 14;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int STATUS_W        = 2;

  // Input tdata field offsets (step count sits on top)
  localparam int IN_YEAR_LSB  = 0;
  localparam int IN_MONTH_LSB = IN_YEAR_LSB + YEAR_W;
  localparam int IN_DAY_LSB   = IN_MONTH_LSB + MONTH_W;
  localparam int IN_STEP_LSB  = IN_DAY_LSB + DAY_W;

  // Output tdata field offsets
  localparam int OUT_YEAR_LSB   = 0;
  localparam int OUT_MONTH_LSB  = OUT_YEAR_LSB + YEAR_W;
  localparam int OUT_DAY_LSB    = OUT_MONTH_LSB + MONTH_W;
  localparam int OUT_MLEN_LSB   = OUT_DAY_LSB + DAY_W;
  localparam int OUT_LEAP_LSB   = OUT_MLEN_LSB + DAY_W;
  localparam int OUT_STATUS_LSB = OUT_LEAP_LSB + 1;
  localparam int OUT_BITS       = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  // Reciprocal for divide by 25: floor(y * 5243 / 2^17) is exact for 14-bit y
  localparam int DIV25_MUL   = 5243;
  localparam int DIV25_SHIFT = 17;
  localparam int QUOT_W      = 10;

  // Month codes used by rollover
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_DEC31 = 5'd31;

  // Reset date
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2000;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
  localparam logic               RST_LEAP  = 1'b1;

  // Register reset values
  localparam logic [YEAR_W-1:0] RST_MIN_YEAR = 14'd1;
  localparam logic [YEAR_W-1:0] RST_MAX_YEAR = 14'd9999;

  // Register indexes (selected by paddr bit 2)
  localparam logic REG_MIN_YEAR = 1'b0;
  localparam logic REG_MAX_YEAR = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LOAD = 2'd1,
    STATUS_RANGE    = 2'd2
  } cds_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WAIT,
    ST_LD_CHECK,
    ST_STEP,
    ST_YR_WAIT,
    ST_YR_UPD,
    ST_DONE
  } cds_state_e;

  // Result of one day of rollover
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               yr_chg;
    logic               err;
  } cds_step_t;

  // Control strobes from the sequencer
  typedef struct packed {
    logic take;
    logic leap_src_load;
    logic ld_commit;
    logic ld_fail;
    logic step_en;
    logic leap_upd;
    logic out_load;
  } cds_ctl_t;

  // Days in a month; zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ design/cds_leap_unit.sv @@
// Leap-year test: registered divide-by-25 stage, then divisibility compare.
module cds_leap_unit (
  input  logic                       clk_i,
  input  logic [cds_pkg::YEAR_W-1:0] year_i,
  output logic                       leap_o
);

  localparam int PROD_W = cds_pkg::YEAR_W + 13;

  logic [PROD_W-1:0]              prod;
  logic [cds_pkg::YEAR_W-1:0]     year_q;
  logic [cds_pkg::QUOT_W-1:0]     quot_q;
  logic [cds_pkg::YEAR_W-1:0]     quot_ext;
  logic [cds_pkg::YEAR_W-1:0]     times25;
  logic                           div25;

  // Multiply by the reciprocal of 25
  assign prod = PROD_W'(year_i) * PROD_W'(cds_pkg::DIV25_MUL);

  // Capture year and quotient
  always_ff @(posedge clk_i) begin
    year_q <= year_i;
    quot_q <= prod[cds_pkg::DIV25_SHIFT +: cds_pkg::QUOT_W];
  end

  // Rebuild quotient times 25 with shifts and compare
  assign quot_ext = cds_pkg::YEAR_W'(quot_q);
  assign times25  = (quot_ext << 4) + (quot_ext << 3) + quot_ext;
  assign div25    = (times25 == year_q);

  // Divisible by 4 and not by 100, or by 400
  assign leap_o = (year_q[1:0] == 2'b00) && (!div25 || (year_q[3:0] == 4'b0000));

endmodule

@@ design/cds_day_step.sv @@
// One day of rollover forward or back with the year range check.
module cds_day_step (
  input  logic [cds_pkg::YEAR_W-1:0]  year_i,
  input  logic [cds_pkg::MONTH_W-1:0] month_i,
  input  logic [cds_pkg::DAY_W-1:0]   day_i,
  input  logic                        leap_i,
  input  logic                        back_i,
  input  logic [cds_pkg::YEAR_W-1:0]  min_year_i,
  input  logic [cds_pkg::YEAR_W-1:0]  max_year_i,
  output cds_pkg::cds_step_t          step_o
);

  logic [cds_pkg::YEAR_W:0]     year_inc;
  logic [cds_pkg::YEAR_W-1:0]   year_dec;
  logic                         inc_ok;
  logic                         dec_ok;
  logic [cds_pkg::DAY_W-1:0]    len_cur;
  logic [cds_pkg::DAY_W-1:0]    len_prev;
  logic [cds_pkg::MONTH_W-1:0]  month_prev;

  // Neighbor years and their range checks
  assign year_inc = {1'b0, year_i} + (cds_pkg::YEAR_W+1)'(1);
  assign year_dec = year_i - cds_pkg::YEAR_W'(1);
  assign inc_ok   = !year_inc[cds_pkg::YEAR_W] &&
                    (year_inc[cds_pkg::YEAR_W-1:0] >= min_year_i) &&
                    (year_inc[cds_pkg::YEAR_W-1:0] <= max_year_i);
  assign dec_ok   = (year_i != '0) && (year_dec >= min_year_i) && (year_dec <= max_year_i);

  assign month_prev = month_i - cds_pkg::MONTH_W'(1);
  assign len_cur    = cds_pkg::month_len(month_i, leap_i);
  assign len_prev   = cds_pkg::month_len(month_prev, leap_i);

  // Pick the next date
  always_comb begin
    step_o        = '0;
    step_o.year   = year_i;
    step_o.month  = month_i;
    step_o.day    = day_i;
    if (!back_i) begin
      priority if (day_i < len_cur) begin
        step_o.day = day_i + cds_pkg::DAY_W'(1);
      end else if (month_i >= cds_pkg::MONTH_DEC) begin
        if (inc_ok) begin
          step_o.year   = year_inc[cds_pkg::YEAR_W-1:0];
          step_o.month  = cds_pkg::MONTH_JAN;
          step_o.day    = cds_pkg::DAY_FIRST;
          step_o.yr_chg = 1'b1;
        end else begin
          step_o.err = 1'b1;
        end
      end else begin
        step_o.month = month_i + cds_pkg::MONTH_W'(1);
        step_o.day   = cds_pkg::DAY_FIRST;
      end
    end else begin
      priority if (day_i > cds_pkg::DAY_FIRST) begin
        step_o.day = day_i - cds_pkg::DAY_W'(1);
      end else if (month_i <= cds_pkg::MONTH_JAN) begin
        if (dec_ok) begin
          step_o.year   = year_dec;
          step_o.month  = cds_pkg::MONTH_DEC;
          step_o.day    = cds_pkg::DAY_DEC31;
          step_o.yr_chg = 1'b1;
        end else begin
          step_o.err = 1'b1;
        end
      end else begin
        step_o.month = month_prev;
        step_o.day   = len_prev;
      end
    end
  end

endmodule

@@ design/calendar_date_stepper_core.sv @@
// A load item passes ST_LD_WAIT and ST_LD_CHECK; a step item of up to 2^(COUNT_WIDTH-1)
// days spends ST_STEP on each day, plus ST_YR_WAIT and ST_YR_UPD at each year crossed, and a
// zero count skips to ST_DONE. One item at a time; the next item is taken in the cycle after
// the result is loaded, which waits while the output still holds an unaccepted result. The
// rollover unit advances one day per cycle, held in ST_YR_WAIT and ST_YR_UPD at year ends.
// Reset (async, active low): date 2000-01-01, min_year 1, max_year 9999, output empty.
module calendar_date_stepper_core #(
  parameter int COUNT_WIDTH = cds_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: load_year[13:0], load_month[17:14], load_day[22:18], step_count[23+:COUNT_WIDTH]
  input  logic [((cds_pkg::IN_STEP_LSB+COUNT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: mode (0 load, 1 step)
  input  logic                   s_axis_tuser,
  // Result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: date_year[13:0], date_month[17:14], date_day[22:18], month_length[27:23],
  //        leap_flag[28], status[30:29]
  output logic [cds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int YW = cds_pkg::YEAR_W;
  localparam int MW = cds_pkg::MONTH_W;
  localparam int DW = cds_pkg::DAY_W;

  cds_pkg::cds_state_e state_q, state_d;
  cds_pkg::cds_ctl_t   ctl;
  cds_pkg::cds_step_t  step;
  cds_pkg::cds_status_e status_q;

  logic [YW-1:0] min_year_q, max_year_q;
  logic [YW-1:0] cur_year_q;
  logic [MW-1:0] cur_month_q;
  logic [DW-1:0] cur_day_q;
  logic          cur_leap_q;

  logic [YW-1:0]          ld_year_q;
  logic [MW-1:0]          ld_month_q;
  logic [DW-1:0]          ld_day_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   back_q;

  logic [COUNT_WIDTH-1:0] in_count;
  logic                   in_back;
  logic [COUNT_WIDTH-1:0] in_mag;
  logic [YW-1:0]          leap_year;
  logic                   leap;
  logic                   ld_ok;
  logic                   out_free;
  logic                   cfg_wr;

  logic                            m_valid_q;
  logic [cds_pkg::OUT_TDATA_W-1:0] m_data_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= cds_pkg::RST_MIN_YEAR;
      max_year_q <= cds_pkg::RST_MAX_YEAR;
    end else if (cfg_wr) begin
      if (paddr[2] == cds_pkg::REG_MIN_YEAR) min_year_q <= pwdata[YW-1:0];
      else                                   max_year_q <= pwdata[YW-1:0];
    end
  end

  assign prdata = (paddr[2] == cds_pkg::REG_MIN_YEAR) ? 32'(min_year_q) : 32'(max_year_q);

  // Decode the step count into direction and magnitude
  assign in_count = s_axis_tdata[cds_pkg::IN_STEP_LSB +: COUNT_WIDTH];
  assign in_back  = in_count[COUNT_WIDTH-1];
  assign in_mag   = in_back ? (~in_count + COUNT_WIDTH'(1)) : in_count;

  // Shared leap unit: load year while checking a load, else the current year
  assign leap_year = ctl.leap_src_load ? ld_year_q : cur_year_q;

  cds_leap_unit u_leap (
    .clk_i  (clk_i),
    .year_i (leap_year),
    .leap_o (leap)
  );

  // Shared day rollover unit
  cds_day_step u_step (
    .year_i     (cur_year_q),
    .month_i    (cur_month_q),
    .day_i      (cur_day_q),
    .leap_i     (cur_leap_q),
    .back_i     (back_q),
    .min_year_i (min_year_q),
    .max_year_i (max_year_q),
    .step_o     (step)
  );

  // Load validation against range and month length
  assign ld_ok = (ld_year_q >= min_year_q) && (ld_year_q <= max_year_q) &&
                 (ld_month_q >= cds_pkg::MONTH_JAN) && (ld_month_q <= cds_pkg::MONTH_DEC) &&
                 (ld_day_q >= cds_pkg::DAY_FIRST) &&
                 (ld_day_q <= cds_pkg::month_len(ld_month_q, leap));

  assign out_free = !m_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cds_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser)        state_d = cds_pkg::ST_LD_WAIT;
          else if (in_mag != '0)    state_d = cds_pkg::ST_STEP;
          else                      state_d = cds_pkg::ST_DONE;
        end
      end
      cds_pkg::ST_LD_WAIT:  state_d = cds_pkg::ST_LD_CHECK;
      cds_pkg::ST_LD_CHECK: state_d = cds_pkg::ST_DONE;
      cds_pkg::ST_STEP: begin
        priority if (step.err)                  state_d = cds_pkg::ST_DONE;
        else if (step.yr_chg)                   state_d = cds_pkg::ST_YR_WAIT;
        else if (cnt_q == COUNT_WIDTH'(1))      state_d = cds_pkg::ST_DONE;
        else                                    state_d = cds_pkg::ST_STEP;
      end
      cds_pkg::ST_YR_WAIT: state_d = cds_pkg::ST_YR_UPD;
      cds_pkg::ST_YR_UPD:  state_d = (cnt_q == '0) ? cds_pkg::ST_DONE : cds_pkg::ST_STEP;
      cds_pkg::ST_DONE:    if (out_free) state_d = cds_pkg::ST_IDLE;
      default:             state_d = cds_pkg::ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    ctl           = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      cds_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctl.take      = s_axis_tvalid;
      end
      cds_pkg::ST_LD_WAIT:  ctl.leap_src_load = 1'b1;
      cds_pkg::ST_LD_CHECK: begin
        ctl.ld_commit = ld_ok;
        ctl.ld_fail   = !ld_ok;
      end
      cds_pkg::ST_STEP:    ctl.step_en  = 1'b1;
      cds_pkg::ST_YR_WAIT: ctl.leap_upd = 1'b0;
      cds_pkg::ST_YR_UPD:  ctl.leap_upd = 1'b1;
      cds_pkg::ST_DONE:    ctl.out_load = out_free;
      default:             ctl = '0;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cds_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Latch item fields on acceptance
  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      ld_year_q  <= s_axis_tdata[cds_pkg::IN_YEAR_LSB +: YW];
      ld_month_q <= s_axis_tdata[cds_pkg::IN_MONTH_LSB +: MW];
      ld_day_q   <= s_axis_tdata[cds_pkg::IN_DAY_LSB +: DW];
      back_q     <= in_back;
    end
  end

  // Day counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      status_q <= cds_pkg::STATUS_OK;
    end else begin
      if (ctl.take) begin
        cnt_q    <= in_mag;
        status_q <= cds_pkg::STATUS_OK;
      end
      if (ctl.ld_fail) status_q <= cds_pkg::STATUS_BAD_LOAD;
      if (ctl.step_en) begin
        if (step.err) status_q <= cds_pkg::STATUS_RANGE;
        else          cnt_q    <= cnt_q - COUNT_WIDTH'(1);
      end
    end
  end

  // Current date and its leap flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= cds_pkg::RST_YEAR;
      cur_month_q <= cds_pkg::RST_MONTH;
      cur_day_q   <= cds_pkg::RST_DAY;
      cur_leap_q  <= cds_pkg::RST_LEAP;
    end else begin
      if (ctl.ld_commit) begin
        cur_year_q  <= ld_year_q;
        cur_month_q <= ld_month_q;
        cur_day_q   <= ld_day_q;
        cur_leap_q  <= leap;
      end
      if (ctl.step_en && !step.err) begin
        cur_year_q  <= step.year;
        cur_month_q <= step.month;
        cur_day_q   <= step.day;
      end
      if (ctl.leap_upd) cur_leap_q <= leap;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Pack the result fields from the year up, zero pad on top
  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      m_data_q <= {{(cds_pkg::OUT_TDATA_W - cds_pkg::OUT_BITS){1'b0}},
                   status_q,
                   cur_leap_q,
                   cds_pkg::month_len(cur_month_q, cur_leap_q),
                   cur_day_q,
                   cur_month_q,
                   cur_year_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ design/cds_checker.sv @@
// Port-level checker for the calendar date stepper, bound to the top level.
`include "calendar_date_stepper_core_macros.svh"

module cds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [cds_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [cds_pkg::STATUS_W-1:0] st;
  logic [cds_pkg::MONTH_W-1:0]  mon;
  logic [cds_pkg::DAY_W-1:0]    mlen;
  logic                         leap;
  logic                         in_acc;
  logic                         out_stall;
  logic                         st_ok;
  logic                         feb_ok;

  assign st        = m_axis_tdata[cds_pkg::OUT_STATUS_LSB +: cds_pkg::STATUS_W];
  assign mon       = m_axis_tdata[cds_pkg::OUT_MONTH_LSB +: cds_pkg::MONTH_W];
  assign mlen      = m_axis_tdata[cds_pkg::OUT_MLEN_LSB +: cds_pkg::DAY_W];
  assign leap      = m_axis_tdata[cds_pkg::OUT_LEAP_LSB];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign st_ok     = (st == cds_pkg::STATUS_OK) || (st == cds_pkg::STATUS_BAD_LOAD) ||
                     (st == cds_pkg::STATUS_RANGE);
  assign feb_ok    = (mon != cds_pkg::MONTH_FEB) || (mlen == (leap ? 5'd29 : 5'd28));

  // A stalled result stays valid and holds its payload
  `CDS_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_stall, m_axis_tvalid, "result dropped")
  `CDS_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, out_stall, $stable(m_axis_tdata), "data moved")

  // The block works on one item at a time
  `CDS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready, "taken while busy")

  // Status is one of the defined codes
  `CDS_ASSERT(a_status_code, clk_i, rst_ni, !m_axis_tvalid || st_ok, "undefined status")

  // February length follows the leap flag
  `CDS_ASSERT(a_feb_len, clk_i, rst_ni, !m_axis_tvalid || feb_ok, "february length mismatch")

endmodule

bind calendar_date_stepper_core cds_checker u_cds_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the calendar date stepper: loads, day steps and year-range limits.
module testbench;
  import cds_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int STEP_W          = COUNT_WIDTH_DEF;
  localparam int IN_TDATA_W      = ((IN_STEP_LSB + STEP_W + 7) / 8) * 8;
  localparam int ITEMS_PER_PHASE = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LIMIT_TIME      = 2 * CLK_HALF * 20_000_000;
  localparam int NUM_PHASES      = 6;
  localparam int DIRECTED_COUNT  = 25;

  localparam logic       MODE_LOAD     = 1'b0;
  localparam logic       MODE_STEP     = 1'b1;
  localparam logic [2:0] ADDR_MIN_YEAR = {REG_MIN_YEAR, 2'b00};
  localparam logic [2:0] ADDR_MAX_YEAR = {REG_MAX_YEAR, 2'b00};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   mlen;
    logic               leap;
    cds_status_e        status;
  } date_result_t;

  typedef struct packed {
    logic               mode;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [STEP_W-1:0]  count;
    logic               typed;
    date_result_t       want;
  } stim_row_t;

  localparam date_result_t NO_TYPED = '{14'd0, 4'd0, 5'd0, 5'd0, 1'b0, STATUS_OK};

  // Directed items; rows with typed set carry their result, the rest use the predictor
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{MODE_STEP, 14'd9999, 4'd15, 5'd31, 16'h0000, 1'b1,
      '{14'd2000, 4'd1, 5'd1, 5'd31, 1'b1, STATUS_OK}},
    '{MODE_LOAD, 14'd2000, 4'd2, 5'd29, 16'hFFFF, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_OK}},
    '{MODE_LOAD, 14'd1900, 4'd2, 5'd29, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd2023, 4'd0, 5'd10, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd2023, 4'd13, 5'd10, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd2023, 4'd15, 5'd10, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd2023, 4'd4, 5'd31, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd2023, 4'd6, 5'd0, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd0, 4'd1, 5'd1, 16'h0000, 1'b1,
      '{14'd2000, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_BAD_LOAD}},
    '{MODE_LOAD, 14'd9999, 4'd12, 5'd31, 16'h0000, 1'b1,
      '{14'd9999, 4'd12, 5'd31, 5'd31, 1'b0, STATUS_OK}},
    '{MODE_STEP, 14'd9999, 4'd15, 5'd31, 16'h0001, 1'b1,
      '{14'd9999, 4'd12, 5'd31, 5'd31, 1'b0, STATUS_RANGE}},
    '{MODE_LOAD, 14'd1, 4'd1, 5'd1, 16'h0000, 1'b1,
      '{14'd1, 4'd1, 5'd1, 5'd31, 1'b0, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'hFFFF, 1'b1,
      '{14'd1, 4'd1, 5'd1, 5'd31, 1'b0, STATUS_RANGE}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'h7FFF, 1'b0, NO_TYPED},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'h8000, 1'b0, NO_TYPED},
    '{MODE_LOAD, 14'd2024, 4'd2, 5'd28, 16'h7FFF, 1'b1,
      '{14'd2024, 4'd2, 5'd28, 5'd29, 1'b1, STATUS_OK}},
    '{MODE_STEP, 14'd9999, 4'd15, 5'd31, 16'h0001, 1'b1,
      '{14'd2024, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'h0001, 1'b1,
      '{14'd2024, 4'd3, 5'd1, 5'd31, 1'b1, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'hFFFF, 1'b1,
      '{14'd2024, 4'd2, 5'd29, 5'd29, 1'b1, STATUS_OK}},
    '{MODE_LOAD, 14'd2023, 4'd12, 5'd31, 16'h8000, 1'b1,
      '{14'd2023, 4'd12, 5'd31, 5'd31, 1'b0, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'h0001, 1'b1,
      '{14'd2024, 4'd1, 5'd1, 5'd31, 1'b1, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'hFFFF, 1'b1,
      '{14'd2023, 4'd12, 5'd31, 5'd31, 1'b0, STATUS_OK}},
    '{MODE_LOAD, 14'd2100, 4'd2, 5'd28, 16'h0000, 1'b1,
      '{14'd2100, 4'd2, 5'd28, 5'd28, 1'b0, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'h0001, 1'b1,
      '{14'd2100, 4'd3, 5'd1, 5'd31, 1'b0, STATUS_OK}},
    '{MODE_STEP, 14'd0, 4'd0, 5'd0, 16'hFF9C, 1'b0, NO_TYPED}
  };

  // Register settings and idling per random phase
  localparam int PHASE_MIN    [NUM_PHASES] = '{2020, 1, 9999, 3000, 1, 1896};
  localparam int PHASE_MAX    [NUM_PHASES] = '{2030, 9999, 9999, 2000, 1, 1904};
  localparam int PHASE_SIDLE  [NUM_PHASES] = '{0, 68, 0, 17, 0, 17};
  localparam int PHASE_RSTALL [NUM_PHASES] = '{0, 0, 68, 17, 68, 17};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [2:0]             paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // Calendar predictor state and register copies
  logic [YEAR_W-1:0]  cal_year  = RST_YEAR;
  logic [MONTH_W-1:0] cal_month = RST_MONTH;
  logic [DAY_W-1:0]   cal_day   = RST_DAY;
  logic [YEAR_W-1:0]  lim_min   = RST_MIN_YEAR;
  logic [YEAR_W-1:0]  lim_max   = RST_MAX_YEAR;

  date_result_t expected_dates [$];

  int mismatch_count      = 0;
  int sender_idle_pct     = 0;
  int receiver_stall_pct  = 0;
  int hold_off_left       = 0;
  int n_items             = 0;
  int n_loads             = 0;
  int n_refused           = 0;
  int n_steps             = 0;
  int n_range_stops       = 0;

  calendar_date_stepper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic logic is_leap_year(input logic [YEAR_W-1:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic [YEAR_W-1:0]  y);
    if (m == 0 || m > MONTH_DEC) return 5'd0;
    if (m == MONTH_FEB) return is_leap_year(y) ? 5'd29 : 5'd28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 5'd30;
    return 5'd31;
  endfunction

  function automatic bit year_allowed(input int y);
    return y >= 0 && y <= 16383 && y >= int'(lim_min) && y <= int'(lim_max);
  endfunction

  // Advance one day; refuse a year change that leaves the range
  function automatic bit roll_forward();
    if (cal_day < days_in_month(cal_month, cal_year)) begin
      cal_day = cal_day + DAY_W'(1);
    end else if (cal_month >= MONTH_DEC) begin
      if (!year_allowed(int'(cal_year) + 1)) return 1'b0;
      cal_year  = cal_year + YEAR_W'(1);
      cal_month = MONTH_JAN;
      cal_day   = DAY_FIRST;
    end else begin
      cal_month = cal_month + MONTH_W'(1);
      cal_day   = DAY_FIRST;
    end
    return 1'b1;
  endfunction

  // Go back one day; refuse a year change that leaves the range
  function automatic bit roll_back();
    if (cal_day > DAY_FIRST) begin
      cal_day = cal_day - DAY_W'(1);
    end else if (cal_month <= MONTH_JAN) begin
      if (cal_year == 0 || !year_allowed(int'(cal_year) - 1)) return 1'b0;
      cal_year  = cal_year - YEAR_W'(1);
      cal_month = MONTH_DEC;
      cal_day   = DAY_DEC31;
    end else begin
      cal_month = cal_month - MONTH_W'(1);
      cal_day   = days_in_month(cal_month, cal_year);
    end
    return 1'b1;
  endfunction

  // Apply one item to the predicted calendar and return the date it reports
  function automatic date_result_t advance_calendar(input logic               mode,
                                                    input logic [YEAR_W-1:0]  y,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [DAY_W-1:0]   d,
                                                    input logic [STEP_W-1:0]  cnt);
    date_result_t r;
    cds_status_e  st;
    int unsigned  mag;
    int unsigned  k;
    bit           backward;
    bit           ok;
    st = STATUS_OK;
    if (mode == MODE_LOAD) begin
      if (year_allowed(int'(y)) && m >= 1 && m <= MONTH_DEC && d >= 1 &&
          d <= days_in_month(m, y)) begin
        cal_year  = y;
        cal_month = m;
        cal_day   = d;
      end else begin
        st = STATUS_BAD_LOAD;
      end
    end else begin
      backward = cnt[STEP_W-1];
      mag = backward ? (32'd1 << STEP_W) - 32'(cnt) : 32'(cnt);
      k = 0;
      while (k < mag && st == STATUS_OK) begin
        ok = backward ? roll_back() : roll_forward();
        if (!ok) st = STATUS_RANGE;
        k++;
      end
    end
    r.year   = cal_year;
    r.month  = cal_month;
    r.day    = cal_day;
    r.mlen   = days_in_month(cal_month, cal_year);
    r.leap   = is_leap_year(cal_year);
    r.status = st;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one item at the falling edge, wait for acceptance and record its date
  task automatic offer_item(input logic               mode,
                            input logic [YEAR_W-1:0]  y,
                            input logic [MONTH_W-1:0] m,
                            input logic [DAY_W-1:0]   d,
                            input logic [STEP_W-1:0]  cnt,
                            input logic               typed,
                            input date_result_t       typed_want);
    date_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_STEP_LSB - STEP_W){1'b0}}, cnt, d, m, y};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_calendar(mode, y, m, d, cnt);
    expected_dates.push_back(typed ? typed_want : predicted);
    n_items++;
    if (mode == MODE_LOAD) n_loads++;
    else n_steps++;
    if (predicted.status == STATUS_BAD_LOAD) n_refused++;
    if (predicted.status == STATUS_RANGE) n_range_stops++;
    @(negedge clk_i);
  endtask

  // Random item: loads aim near the year range and month ends, steps mostly short
  task automatic offer_random_item();
    int                 lo;
    int                 hi;
    int                 len;
    int                 sel;
    int                 mag;
    logic               mode;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [STEP_W-1:0]  cnt;
    lo = (lim_min < lim_max) ? int'(lim_min) : int'(lim_max);
    hi = (lim_min < lim_max) ? int'(lim_max) : int'(lim_min);
    mode = ($urandom_range(0, 99) < 40) ? MODE_LOAD : MODE_STEP;
    if (mode == MODE_LOAD) begin
      if ($urandom_range(0, 99) < 75)
        y = YEAR_W'($urandom_range(lo > 2 ? lo - 2 : 0, hi + 2 > 9999 ? 9999 : hi + 2));
      else
        y = YEAR_W'($urandom_range(0, 9999));
      m = MONTH_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                 : $urandom_range(0, 15));
      len = int'(days_in_month(m, y));
      sel = $urandom_range(0, 99);
      if (sel < 55)
        d = DAY_W'($urandom_range(1, len == 0 ? 31 : len));
      else if (sel < 85)
        d = DAY_W'($urandom_range(len > 0 ? len - 1 : 0, len + 1 > 31 ? 31 : len + 1));
      else
        d = DAY_W'($urandom_range(0, 31));
      cnt = STEP_W'($urandom_range(0, 65535));
    end else begin
      y = YEAR_W'($urandom_range(0, 9999));
      m = MONTH_W'($urandom_range(0, 15));
      d = DAY_W'($urandom_range(0, 31));
      sel = $urandom_range(0, 99);
      if (sel < 55)      mag = $urandom_range(0, 40);
      else if (sel < 85) mag = $urandom_range(41, 800);
      else if (sel < 97) mag = $urandom_range(801, 6000);
      else               mag = $urandom_range(6001, 32767);
      cnt = ($urandom_range(0, 1) == 1) ? STEP_W'(-mag) : STEP_W'(mag);
    end
    offer_item(mode, y, m, d, cnt, 1'b0, NO_TYPED);
  endtask

  // Write a register, then read it back
  task automatic write_reg(input logic [2:0] addr, input logic [YEAR_W-1:0] value,
                           input string name);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {{(32 - YEAR_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (addr == ADDR_MIN_YEAR) lim_min = value;
    else lim_max = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field(name, value, prdata[YEAR_W-1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until every expected date has come back, then let the block settle
  task automatic drain_results();
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: stall at random, or hold off for a counted stretch
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expected date
  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_dates.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("date_year", want.year, m_axis_tdata[OUT_YEAR_LSB +: YEAR_W]);
        check_field("date_month", want.month, m_axis_tdata[OUT_MONTH_LSB +: MONTH_W]);
        check_field("date_day", want.day, m_axis_tdata[OUT_DAY_LSB +: DAY_W]);
        check_field("month_length", want.mlen, m_axis_tdata[OUT_MLEN_LSB +: DAY_W]);
        check_field("leap_flag", want.leap, m_axis_tdata[OUT_LEAP_LSB]);
        check_field("status", want.status, m_axis_tdata[OUT_STATUS_LSB +: STATUS_W]);
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items at reset register values, no idling
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      offer_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].year, DIRECTED_ROWS[i].month,
                 DIRECTED_ROWS[i].day, DIRECTED_ROWS[i].count, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].want);
    end
    s_axis_tvalid <= 1'b0;
    drain_results();

    // Random phases, each under its own year range and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(ADDR_MIN_YEAR, YEAR_W'(PHASE_MIN[p]), "min_year");
      write_reg(ADDR_MAX_YEAR, YEAR_W'(PHASE_MAX[p]), "max_year");
      sender_idle_pct    = PHASE_SIDLE[p];
      receiver_stall_pct = PHASE_RSTALL[p];
      if (p == 0) hold_off_left = HOLD_OFF_CYCLES;
      // Short forward step first: the date may lie outside the new range
      offer_item(MODE_STEP, '0, '0, '0, STEP_W'($urandom_range(1, 5)), 1'b0, NO_TYPED);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) offer_random_item();
      s_axis_tvalid <= 1'b0;
      drain_results();
    end

    $display("Covered %0d items: %0d loads (%0d refused), %0d steps (%0d stopped at range).",
             n_items, n_loads, n_refused, n_steps, n_range_stops);
    $display("Year ranges: reset values plus %0d written settings, one of them empty.",
             NUM_PHASES);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
